// File: rtl/ccs_pkg.sv
// ccs_pkg: shared types, constants, microcode program and round helpers
// for the ChaCha stream cipher. No dependencies.
package ccs_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned WORDS    = 16;
	localparam int unsigned CFG_W    = 64;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned RC_W     = 5;
	localparam int unsigned DBL_W    = 5;
	localparam int unsigned PC_W     = 4;

	localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
	localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646e;
	localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2d32;
	localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b20_6574;

	localparam logic [RC_W-1:0] RC_RESET = 5'd20;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd6;

	// datapath operations
	localparam logic [1:0] OP_NOP   = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_QSTEP = 2'd2;
	localparam logic [1:0] OP_FINAL = 2'd3;

	// sequencer jumps
	localparam logic [1:0] JMP_NEXT = 2'd0;
	localparam logic [1:0] JMP_ZERO = 2'd1;
	localparam logic [1:0] JMP_LOOP = 2'd2;
	localparam logic [1:0] JMP_END  = 2'd3;

	localparam logic [PC_W-1:0] PC_ROUND = 4'd1;
	localparam logic [PC_W-1:0] PC_FINAL = 4'd9;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] step;
		logic       diag;
	} ctl_t;

	typedef struct packed {
		ctl_t            ctl;
		logic [1:0]      jmp;
		logic [PC_W-1:0] target;
	} uword_t;

	// program: load, column round, diagonal round (looped), feed-forward, result
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			4'd0:    w = '{ctl: '{OP_LOAD,  2'd0, 1'b0}, jmp: JMP_ZERO, target: PC_FINAL};
			4'd1:    w = '{ctl: '{OP_QSTEP, 2'd0, 1'b0}, jmp: JMP_NEXT, target: PC_ROUND};
			4'd2:    w = '{ctl: '{OP_QSTEP, 2'd1, 1'b0}, jmp: JMP_NEXT, target: PC_ROUND};
			4'd3:    w = '{ctl: '{OP_QSTEP, 2'd2, 1'b0}, jmp: JMP_NEXT, target: PC_ROUND};
			4'd4:    w = '{ctl: '{OP_QSTEP, 2'd3, 1'b0}, jmp: JMP_NEXT, target: PC_ROUND};
			4'd5:    w = '{ctl: '{OP_QSTEP, 2'd0, 1'b1}, jmp: JMP_NEXT, target: PC_ROUND};
			4'd6:    w = '{ctl: '{OP_QSTEP, 2'd1, 1'b1}, jmp: JMP_NEXT, target: PC_ROUND};
			4'd7:    w = '{ctl: '{OP_QSTEP, 2'd2, 1'b1}, jmp: JMP_NEXT, target: PC_ROUND};
			4'd8:    w = '{ctl: '{OP_QSTEP, 2'd3, 1'b1}, jmp: JMP_LOOP, target: PC_ROUND};
			4'd9:    w = '{ctl: '{OP_FINAL, 2'd0, 1'b0}, jmp: JMP_NEXT, target: PC_ROUND};
			default: w = '{ctl: '{OP_NOP,   2'd0, 1'b0}, jmp: JMP_END,  target: PC_ROUND};
		endcase
		return w;
	endfunction

	// state word index of a quarter-round row for a lane
	function automatic logic [3:0] lane_idx(input logic [1:0] row, input logic [1:0] lane,
			input logic diag);
		logic [1:0] col;
		col = diag ? lane + row : lane;
		return {row, col};
	endfunction

	function automatic logic [WORD_W-1:0] step_rot(input logic [WORD_W-1:0] v,
			input logic [1:0] step);
		logic [WORD_W-1:0] r;
		case (step)
			2'd0:    r = {v[15:0], v[31:16]};
			2'd1:    r = {v[19:0], v[31:20]};
			2'd2:    r = {v[23:0], v[31:24]};
			default: r = {v[24:0], v[31:25]};
		endcase
		return r;
	endfunction

endpackage

// File: rtl/ccs_in_if.sv
// ccs_in_if: input byte channel (valid/ready with data and message start flag).
// Depends on nothing.
interface ccs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_in;
	logic       message_start;

	modport source (output valid, output data_in, output message_start, input ready);
	modport sink   (input valid, input data_in, input message_start, output ready);
endinterface

// File: rtl/ccs_out_if.sv
// ccs_out_if: output byte channel (valid/ready with result byte).
// Depends on nothing.
interface ccs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;

	modport source (output valid, output data_out, input ready);
	modport sink   (input valid, input data_out, output ready);
endinterface

// File: rtl/ccs_sequencer.sv
// ccs_sequencer: step counter over the microcode program, double-round loop count.
// Depends on ccs_pkg.
module ccs_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [ccs_pkg::RC_W-1:0]    round_count,
	output ccs_pkg::ctl_t               ctl,
	output logic                        done
);

	logic                        running_q;
	logic [ccs_pkg::PC_W-1:0]    pc_q;
	logic [ccs_pkg::DBL_W-1:0]   rem_q;
	ccs_pkg::uword_t             word;
	logic [ccs_pkg::DBL_W:0]     rc_inc;
	logic [ccs_pkg::DBL_W-1:0]   doubles;

	assign word    = ccs_pkg::ucode(pc_q);
	assign rc_inc  = {1'b0, round_count} + 6'd1;
	assign doubles = rc_inc[ccs_pkg::DBL_W:1];

	always_comb begin
		ctl = word.ctl;
		if (!running_q) begin
			ctl.op = ccs_pkg::OP_NOP;
		end
	end

	assign done = running_q && (word.jmp == ccs_pkg::JMP_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			pc_q      <= '0;
			rem_q     <= '0;
		end else if (go) begin
			running_q <= 1'b1;
			pc_q      <= '0;
		end else if (running_q) begin
			unique case (word.jmp)
				ccs_pkg::JMP_NEXT: begin
					pc_q <= pc_q + 4'd1;
				end
				ccs_pkg::JMP_ZERO: begin
					rem_q <= doubles;
					pc_q  <= (doubles == '0) ? word.target : pc_q + 4'd1;
				end
				ccs_pkg::JMP_LOOP: begin
					if (rem_q != 5'd1) begin
						rem_q <= rem_q - 5'd1;
						pc_q  <= word.target;
					end else begin
						pc_q <= pc_q + 4'd1;
					end
				end
				default: begin
					running_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// File: rtl/ccs_datapath.sv
// ccs_datapath: 16-word ChaCha state, four-lane quarter-round step, feed-forward add
// and keystream byte read. Depends on ccs_pkg.
module ccs_datapath (
	input  logic                           clk,
	input  ccs_pkg::ctl_t                  ctl,
	input  logic [3:0][ccs_pkg::CFG_W-1:0] key,
	input  logic [ccs_pkg::CFG_W-1:0]      nonce,
	input  logic [ccs_pkg::CFG_W-1:0]      counter,
	input  logic [ccs_pkg::POS_W-1:0]      rd_pos,
	output logic [7:0]                     ks_byte
);

	logic [ccs_pkg::WORD_W-1:0] work_q [ccs_pkg::WORDS];
	logic [ccs_pkg::WORD_W-1:0] nxt    [ccs_pkg::WORDS];
	logic [ccs_pkg::WORD_W-1:0] init   [ccs_pkg::WORDS];
	logic [ccs_pkg::CFG_W-1:0]  ctr_q;
	logic [3:0]                 ix [4];
	logic [3:0]                 iy [4];
	logic [3:0]                 iz [4];
	logic [ccs_pkg::WORD_W-1:0] sx [4];
	logic [1:0]                 xrow, yrow, zrow;
	logic [ccs_pkg::WORD_W-1:0] rd_word;

	always_comb begin
		init[0]  = ccs_pkg::SIGMA0;
		init[1]  = ccs_pkg::SIGMA1;
		init[2]  = ccs_pkg::SIGMA2;
		init[3]  = ccs_pkg::SIGMA3;
		for (int k = 0; k < 4; k++) begin
			init[4 + 2*k] = key[k][31:0];
			init[5 + 2*k] = key[k][63:32];
		end
		init[12] = ctr_q[31:0];
		init[13] = ctr_q[63:32];
		init[14] = nonce[31:0];
		init[15] = nonce[63:32];
	end

	// steps 0 and 2: a += b, d ^= a; steps 1 and 3: c += d, b ^= c
	assign xrow = ctl.step[0] ? 2'd2 : 2'd0;
	assign yrow = ctl.step[0] ? 2'd3 : 2'd1;
	assign zrow = ctl.step[0] ? 2'd1 : 2'd3;

	always_comb begin
		for (int i = 0; i < ccs_pkg::WORDS; i++) begin
			nxt[i] = work_q[i];
		end
		for (int l = 0; l < 4; l++) begin
			ix[l] = ccs_pkg::lane_idx(xrow, 2'(l), ctl.diag);
			iy[l] = ccs_pkg::lane_idx(yrow, 2'(l), ctl.diag);
			iz[l] = ccs_pkg::lane_idx(zrow, 2'(l), ctl.diag);
			sx[l] = work_q[ix[l]] + work_q[iy[l]];
			nxt[ix[l]] = sx[l];
			nxt[iz[l]] = ccs_pkg::step_rot(work_q[iz[l]] ^ sx[l], ctl.step);
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			ccs_pkg::OP_LOAD: begin
				ctr_q <= counter;
				for (int i = 0; i < ccs_pkg::WORDS; i++) begin
					work_q[i] <= (i == 12) ? counter[31:0] :
						(i == 13) ? counter[63:32] : init[i];
				end
			end
			ccs_pkg::OP_QSTEP: begin
				for (int i = 0; i < ccs_pkg::WORDS; i++) begin
					work_q[i] <= nxt[i];
				end
			end
			ccs_pkg::OP_FINAL: begin
				for (int i = 0; i < ccs_pkg::WORDS; i++) begin
					work_q[i] <= work_q[i] + init[i];
				end
			end
			default: begin
			end
		endcase
	end

	assign rd_word = work_q[rd_pos[5:2]];
	assign ks_byte = rd_word[{rd_pos[1:0], 3'b000} +: 8];

endmodule

// File: rtl/chacha_stream_cipher.sv
// A byte inside the current keystream block loads the result register at its beat.
// A byte that needs a new block (message start or position wrap) loads it after load, D =
// ceil(round_count/2) double rounds on one four-lane step unit and the feed-forward add.
// One byte per cycle within a block while the output is not stalled; none while a block is made.
// Reset: round count 20, key, nonce, counter and position zero; first byte makes a block.
// Depends on ccs_pkg, ccs_in_if, ccs_out_if, ccs_sequencer, ccs_datapath.
module chacha_stream_cipher (
	input  logic                            clk,
	input  logic                            arst_n,
	ccs_in_if.sink                          in_ch,
	ccs_out_if.source                       out_ch,
	input  logic                            cfg_we,
	input  logic [ccs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ccs_pkg::CFG_W-1:0]       cfg_wdata
);

	logic [ccs_pkg::RC_W-1:0]        rounds_q;
	logic [3:0][ccs_pkg::CFG_W-1:0]  key_q;
	logic [ccs_pkg::CFG_W-1:0]       nonce_q;
	logic [ccs_pkg::CFG_W-1:0]       ctr_q;
	logic [ccs_pkg::POS_W-1:0]       pos_q;
	logic                            busy_q;
	logic [7:0]                      hold_q;
	logic                            out_valid_q;
	logic [7:0]                      out_data_q;

	logic                            accept;
	logic                            need_block;
	logic                            go;
	logic                            done;
	ccs_pkg::ctl_t                   ctl;
	logic [ccs_pkg::POS_W-1:0]       rd_pos;
	logic [7:0]                      ks_byte;

	assign in_ch.ready     = !busy_q && (!out_valid_q || out_ch.ready);
	assign accept          = in_ch.valid && in_ch.ready;
	assign need_block      = in_ch.message_start || (pos_q == '0);
	assign go              = accept && need_block;
	assign rd_pos          = busy_q ? '0 : pos_q;
	assign out_ch.valid    = out_valid_q;
	assign out_ch.data_out = out_data_q;

	ccs_sequencer u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.round_count (rounds_q),
		.ctl         (ctl),
		.done        (done)
	);

	ccs_datapath u_dp (
		.clk     (clk),
		.ctl     (ctl),
		.key     (key_q),
		.nonce   (nonce_q),
		.counter (ctr_q),
		.rd_pos  (rd_pos),
		.ks_byte (ks_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rounds_q <= ccs_pkg::RC_RESET;
			key_q    <= '0;
			nonce_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ccs_pkg::REG_ROUNDS: rounds_q <= cfg_wdata[ccs_pkg::RC_W-1:0];
				ccs_pkg::REG_KEY0:   key_q[0] <= cfg_wdata;
				ccs_pkg::REG_KEY1:   key_q[1] <= cfg_wdata;
				ccs_pkg::REG_KEY2:   key_q[2] <= cfg_wdata;
				ccs_pkg::REG_KEY3:   key_q[3] <= cfg_wdata;
				ccs_pkg::REG_NONCE:  nonce_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q       <= '0;
			pos_q       <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == ccs_pkg::REG_START)) begin
				ctr_q <= cfg_wdata;
			end else if (done) begin
				ctr_q <= ctr_q + 64'd1;
			end

			if (go) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end

			if (done) begin
				pos_q <= 6'd1;
			end else if (accept && !need_block) begin
				pos_q <= pos_q + 6'd1;
			end

			if (done || (accept && !need_block)) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			hold_q <= in_ch.data_in;
		end
		if (done) begin
			out_data_q <= hold_q ^ ks_byte;
		end else if (accept && !need_block) begin
			out_data_q <= in_ch.data_in ^ ks_byte;
		end
	end

endmodule

// File: rtl/ccs_checker.sv
// ccs_checker: port-level assertions for chacha_stream_cipher, attached by bind.
// Depends on chacha_stream_cipher port names only.
module ccs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] data_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(data_out))
		else $error("stalled result changed");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result slot full");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid || !in_ready)
		else $error("accepted beat neither answered nor held busy");

endmodule

bind chacha_stream_cipher ccs_checker u_ccs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.data_out  (out_ch.data_out)
);

// File: tb/chacha_stream_cipher_test.sv
// chacha_stream_cipher_test: self-checking bench for the ChaCha byte stream cipher.
// An internal block generator predicts every output byte under randomised handshakes.
// Depends on ccs_pkg, ccs_in_if, ccs_out_if and chacha_stream_cipher.
module chacha_stream_cipher_test;

	localparam logic [ccs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int RANDOM_BYTES = 1900;
	localparam int END_WAIT     = 160;
	localparam int CYCLE_LIMIT  = 1500000;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} byte_item_t;

	logic clk;
	logic arst_n;
	logic                          cfg_we;
	logic [ccs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ccs_pkg::CFG_W-1:0]     cfg_wdata;

	ccs_in_if  in_ch();
	ccs_out_if out_ch();

	chacha_stream_cipher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// predictor copy of registers and cipher state
	logic [4:0]   round_setting = 5'd20;
	logic [63:0]  key_words [4] = '{64'd0, 64'd0, 64'd0, 64'd0};
	logic [63:0]  nonce_word = 64'd0;
	logic [63:0]  blk_ctr = 64'd0;
	logic [511:0] ks_block = '0;
	logic [5:0]   ks_pos = 6'd0;

	byte_item_t   pending_bytes [$];
	logic [7:0]   expected_bytes [$];
	int           err_count = 0;
	int           cycle_count = 0;
	int           gap_left = 0;
	int           stall_left = 0;
	bit           src_gaps = 1'b1;
	bit           snk_stalls = 1'b1;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [127:0] quarter_round(input logic [31:0] a, b, c, d);
		a += b; d ^= a; d = rotl(d, 16);
		c += d; b ^= c; b = rotl(b, 12);
		a += b; d ^= a; d = rotl(d, 8);
		c += d; b ^= c; b = rotl(b, 7);
		return {a, b, c, d};
	endfunction

	// one 64-byte keystream block, byte n at bits 8n+7:8n
	function automatic logic [511:0] keystream_for(input logic [63:0] ctr);
		logic [31:0]  init [16];
		logic [31:0]  w [16];
		logic [511:0] ks;
		int           dbl;
		init[0] = ccs_pkg::SIGMA0;
		init[1] = ccs_pkg::SIGMA1;
		init[2] = ccs_pkg::SIGMA2;
		init[3] = ccs_pkg::SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init[4 + 2 * i] = key_words[i][31:0];
			init[5 + 2 * i] = key_words[i][63:32];
		end
		init[12] = ctr[31:0];
		init[13] = ctr[63:32];
		init[14] = nonce_word[31:0];
		init[15] = nonce_word[63:32];
		w = init;
		dbl = (int'(round_setting) + 1) / 2;
		for (int r = 0; r < dbl; r++) begin
			{w[0], w[4], w[8],  w[12]} = quarter_round(w[0], w[4], w[8],  w[12]);
			{w[1], w[5], w[9],  w[13]} = quarter_round(w[1], w[5], w[9],  w[13]);
			{w[2], w[6], w[10], w[14]} = quarter_round(w[2], w[6], w[10], w[14]);
			{w[3], w[7], w[11], w[15]} = quarter_round(w[3], w[7], w[11], w[15]);
			{w[0], w[5], w[10], w[15]} = quarter_round(w[0], w[5], w[10], w[15]);
			{w[1], w[6], w[11], w[12]} = quarter_round(w[1], w[6], w[11], w[12]);
			{w[2], w[7], w[8],  w[13]} = quarter_round(w[2], w[7], w[8],  w[13]);
			{w[3], w[4], w[9],  w[14]} = quarter_round(w[3], w[4], w[9],  w[14]);
		end
		for (int i = 0; i < 16; i++)
			ks[32 * i +: 32] = w[i] + init[i];
		return ks;
	endfunction

	function automatic int draw_wait(input bit enabled);
		return enabled ? int'($urandom_range(0, 12)) : 0;
	endfunction

	task automatic cipher_byte(input byte_item_t it);
		if (it.start || ks_pos == 6'd0) begin
			ks_block = keystream_for(blk_ctr);
			blk_ctr  = blk_ctr + 64'd1;
			ks_pos   = 6'd0;
		end
		expected_bytes.push_back(it.data ^ ks_block[{ks_pos, 3'b000} +: 8]);
		ks_pos = ks_pos + 6'd1;
	endtask

	task automatic write_reg(input logic [ccs_pkg::CFG_IDX_W-1:0] idx,
			input logic [63:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ccs_pkg::REG_ROUNDS: round_setting = val[4:0];
			ccs_pkg::REG_KEY0:   key_words[0] = val;
			ccs_pkg::REG_KEY1:   key_words[1] = val;
			ccs_pkg::REG_KEY2:   key_words[2] = val;
			ccs_pkg::REG_KEY3:   key_words[3] = val;
			ccs_pkg::REG_NONCE:  nonce_word = val;
			ccs_pkg::REG_START:  blk_ctr = val;
			default:    ;
		endcase
	endtask

	task automatic add_byte(input logic [7:0] data, input logic start);
		pending_bytes.push_back('{data: data, start: start});
	endtask

	task automatic add_message(input int len);
		for (int i = 0; i < len; i++)
			add_byte(8'($urandom), i == 0);
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || in_ch.valid || expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// driver
	always @(posedge clk) begin : drive_bytes
		byte_item_t it;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				cipher_byte('{data: in_ch.data_in, start: in_ch.message_start});
				gap_left = draw_wait(src_gaps);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					it = pending_bytes.pop_front();
					in_ch.valid         <= 1'b1;
					in_ch.data_in       <= it.data;
					in_ch.message_start <= it.start;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : check_bytes
		logic [7:0] want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_bytes.size() == 0) begin
					$error("data_out: unexpected beat, got %02h", out_ch.data_out);
					err_count++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_ch.data_out !== want) begin
						$error("data_out: expected %02h, got %02h", want, out_ch.data_out);
						err_count++;
					end
				end
				stall_left = draw_wait(snk_stalls);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		int          random_sent;
		int          n_msg;
		int          len;
		logic [63:0] v;
		random_sent         = 0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_wdata           = '0;
		in_ch.valid         = 1'b0;
		in_ch.data_in       = 8'h00;
		in_ch.message_start = 1'b0;
		out_ch.ready        = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: first beat must make a block without a start flag
		add_byte(8'h00, 1'b0);
		add_byte(8'hff, 1'b0);
		add_byte(8'ha5, 1'b0);
		add_byte(8'h5a, 1'b0);
		add_byte(8'h00, 1'b1);
		add_byte(8'hff, 1'b1);
		add_byte(8'h3c, 1'b0);
		wait_drained();

		// zero rounds, all-ones key and nonce, counter wraps past 2^64
		write_reg(ccs_pkg::REG_ROUNDS, 64'hffff_ffff_ffff_ffe0);
		write_reg(ccs_pkg::REG_KEY0, '1);
		write_reg(ccs_pkg::REG_KEY1, '1);
		write_reg(ccs_pkg::REG_KEY2, '1);
		write_reg(ccs_pkg::REG_KEY3, '1);
		write_reg(ccs_pkg::REG_NONCE, '1);
		write_reg(ccs_pkg::REG_START, '1);
		add_byte(8'hff, 1'b1);
		add_byte(8'h00, 1'b0);
		add_byte(8'h81, 1'b1);
		add_byte(8'h7e, 1'b1);
		wait_drained();

		// unlisted index ignored; maximum rounds; low word carry into high word
		write_reg(REG_UNUSED, rand64());
		write_reg(ccs_pkg::REG_ROUNDS, 64'd31);
		write_reg(ccs_pkg::REG_KEY0, rand64());
		write_reg(ccs_pkg::REG_KEY1, rand64());
		write_reg(ccs_pkg::REG_KEY2, rand64());
		write_reg(ccs_pkg::REG_KEY3, rand64());
		write_reg(ccs_pkg::REG_NONCE, rand64());
		write_reg(ccs_pkg::REG_START, 64'h0000_0000_ffff_ffff);
		add_byte(8'h12, 1'b1);
		add_byte(8'h34, 1'b1);
		add_byte(8'h56, 1'b0);
		wait_drained();

		// odd count rounds up
		write_reg(ccs_pkg::REG_ROUNDS, 64'd1);
		add_byte(8'hab, 1'b1);
		add_byte(8'hcd, 1'b0);
		wait_drained();
		write_reg(ccs_pkg::REG_ROUNDS, 64'd2);
		write_reg(ccs_pkg::REG_START, 64'd0);
		add_byte(8'hef, 1'b1);
		add_byte(8'h01, 1'b0);
		wait_drained();

		while (random_sent < RANDOM_BYTES) begin
			src_gaps   = $urandom_range(0, 2) != 0;
			snk_stalls = $urandom_range(0, 2) != 0;
			if ($urandom_range(0, 1) == 1) begin
				v = ($urandom_range(0, 1) == 1) ? rand64() : 64'd0;
				case ($urandom_range(0, 7))
					0:       v[4:0] = 5'd0;
					1:       v[4:0] = 5'd1;
					2:       v[4:0] = 5'd2;
					3:       v[4:0] = 5'd20;
					4:       v[4:0] = 5'd31;
					default: v[4:0] = 5'($urandom_range(0, 31));
				endcase
				write_reg(ccs_pkg::REG_ROUNDS, v);
			end
			if ($urandom_range(0, 2) == 0) begin
				write_reg(ccs_pkg::REG_KEY0, rand64());
				write_reg(ccs_pkg::REG_KEY1, rand64());
				write_reg(ccs_pkg::REG_KEY2, rand64());
				write_reg(ccs_pkg::REG_KEY3, rand64());
			end
			if ($urandom_range(0, 2) == 0)
				write_reg(ccs_pkg::REG_NONCE, rand64());
			if ($urandom_range(0, 1) == 1) begin
				case ($urandom_range(0, 4))
					0:       v = 64'd0;
					1:       v = '1;
					2:       v = 64'hffff_ffff_ffff_fffe;
					3:       v = 64'h0000_0000_ffff_fffe;
					default: v = rand64();
				endcase
				write_reg(ccs_pkg::REG_START, v);
			end
			n_msg = $urandom_range(1, 5);
			repeat (n_msg) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: start flags anywhere
					len = $urandom_range(1, 20);
					repeat (len)
						add_byte(8'($urandom), $urandom_range(0, 3) == 0);
				end else begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
						: $urandom_range(1, 70);
					add_message(len);
				end
				random_sent += len;
			end
			wait_drained();
		end

		repeat (END_WAIT) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: files.f
rtl/ccs_pkg.sv
rtl/ccs_in_if.sv
rtl/ccs_out_if.sv
rtl/ccs_sequencer.sv
rtl/ccs_datapath.sv
rtl/chacha_stream_cipher.sv
rtl/ccs_checker.sv
tb/chacha_stream_cipher_test.sv
